### src/vcd_pkg.sv
// velocity command deframer package: frame constants and the result type
// no dependencies; used by velocity_command_deframer and vcd_checker
package vcd_pkg;

  // frame layout
  localparam int unsigned WindowLen = 10;
  localparam int unsigned CntW      = 4;
  localparam int unsigned VelW      = 16;

  // marker bytes
  localparam logic [7:0] HeadFirst  = 8'hA5;
  localparam logic [7:0] HeadSecond = 8'h5A;
  localparam logic [7:0] TailByte   = 8'hEE;

  // one decoded velocity command
  typedef struct packed {
    logic signed [VelW-1:0] vel_z;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] vel_x;
  } vel_cmd_t;

  localparam int unsigned OutDataW = $bits(vel_cmd_t);

endpackage

### src/velocity_command_deframer.sv
// velocity command deframer top level: byte window, frame check, output skid
// depends on vcd_pkg
//
// Takes one received byte per word on the slave side and keeps the last ten
// bytes of the current chunk in a shift window. When the window holds ten
// eligible bytes starting A5 5A, ending EE, with byte 8 equal to the XOR of
// bytes 0..7, one word with three signed big-endian velocities goes out.
// tuser on the input marks the first byte of a chunk and clears the window
// before that byte enters. After a good frame nine more bytes pass before the
// next frame can complete. The window shift, the XOR check and the counter update
// sit between the window register and the output register, so a byte is accepted
// in each cycle unless tready is low. A two-entry output stage (output register
// plus skid) keeps input flowing while a result waits; tready drops only when both
// entries hold results. A result from the last frame byte is registered in the
// output register, or in the skid entry while the output register is stalled.
module velocity_command_deframer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,  // [7:0] rx_byte
  input  logic                     s_axis_tuser_i,  // [0] chunk_start
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [vcd_pkg::OutDataW-1:0] m_axis_tdata_o // [15:0] vel_x, [31:16] vel_y,
                                                      // [47:32] vel_z
);
  import vcd_pkg::*;

  logic [7:0]     win_q [WindowLen];
  logic [7:0]     win_d [WindowLen];
  logic [CntW-1:0] cnt_q, cnt_d, cnt_base;
  logic           accept;
  logic           frame_ok;
  logic [7:0]     xor_sum;
  vel_cmd_t       res;
  vel_cmd_t       out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           pop;
  logic           res_valid;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !skid_valid_q;

  // next window: clear on chunk start, then shift the new byte in
  always_comb begin
    for (int i = 0; i < WindowLen - 1; i++) begin
      win_d[i] = s_axis_tuser_i ? 8'h00 : win_q[i+1];
    end
    win_d[WindowLen-1] = s_axis_tdata_i;
  end

  // eligible byte count, saturating at the window length
  always_comb begin
    cnt_base = s_axis_tuser_i ? '0 : cnt_q;
    if (cnt_base < CntW'(WindowLen)) begin
      cnt_d = cnt_base + CntW'(1);
    end else begin
      cnt_d = CntW'(WindowLen);
    end
  end

  // frame check on the updated window
  always_comb begin
    xor_sum = 8'h00;
    for (int i = 0; i < 8; i++) begin
      xor_sum = xor_sum ^ win_d[i];
    end
    frame_ok = (cnt_d == CntW'(WindowLen)) &&
               (win_d[0] == HeadFirst) && (win_d[1] == HeadSecond) &&
               (win_d[9] == TailByte) && (win_d[8] == xor_sum);
    res.vel_x = {win_d[2], win_d[3]};
    res.vel_y = {win_d[4], win_d[5]};
    res.vel_z = {win_d[6], win_d[7]};
  end

  assign res_valid = accept && frame_ok;

  // window and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < WindowLen; i++) begin
        win_q[i] <= 8'h00;
      end
    end else if (accept) begin
      cnt_q <= frame_ok ? '0 : cnt_d;
      for (int i = 0; i < WindowLen; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // output register and skid entry
  assign pop = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

### src/vcd_checker.sv
// port-level checker for velocity_command_deframer, bound to the top level
// depends on vcd_pkg
module vcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [vcd_pkg::OutDataW-1:0] m_axis_tdata_o   // vel_x, vel_y, vel_z
);
  import vcd_pkg::*;

  // a stalled result word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result word changed while stalled");

  // input stalls only while a result is pending at the output
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

  // skid fills only from an accepted byte while the output was blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |->
      $past(s_axis_tvalid_i && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stall without a blocked result");

  // a new result appears only after an accepted byte
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result word without an accepted byte");

endmodule

bind velocity_command_deframer vcd_checker u_vcd_checker (.*);
